// ===== rtl/hsi_pkg.sv =====
// Shared types and constants of the Hermite stroke interpolator.
package hsi_pkg;

    localparam int MAX_STEPS_DEF = 64;
    localparam int FRAC_BITS_DEF = 4;
    localparam int STEP_LONG_PX  = 20;
    localparam int STEP_SHORT_PX = 5;
    localparam int QUEUE_DEPTH   = 2;

    // Step counts up to 64 fit in seven bits.
    localparam int CNT_W = 7;
    localparam int POS_W = 16;
    localparam int VEL_W = 17;
    localparam int OUT_W = 19;

    localparam logic [1:0] MODE_RAINBOW   = 2'd2;
    localparam logic [1:0] MODE_EXPLOSIVE = 2'd3;

    localparam logic [1:0] KIND_BLUE      = 2'd0;
    localparam logic [1:0] KIND_RAINBOW   = 2'd1;
    localparam logic [1:0] KIND_EXPLOSIVE = 2'd2;

    // One curve segment handed from the front part to the back part.
    typedef struct packed {
        logic        [POS_W-1:0] p0x;
        logic        [POS_W-1:0] p0y;
        logic        [POS_W-1:0] p1x;
        logic        [POS_W-1:0] p1y;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] dx;
        logic signed [VEL_W-1:0] dy;
        logic        [CNT_W-1:0] n;
        logic        [1:0]       kind;
    } cmd_t;

endpackage

// ===== rtl/hsi_front.sv =====
// Front part: takes samples, tracks stroke state, finds the step count of each segment.
module hsi_front #(
    parameter int MAX_STEPS = hsi_pkg::MAX_STEPS_DEF,
    parameter int FRAC_BITS = hsi_pkg::FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     pen_down,
    input  logic [hsi_pkg::POS_W-1:0] pos_x,
    input  logic [hsi_pkg::POS_W-1:0] pos_y,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_data,
    output logic                     push,
    output hsi_pkg::cmd_t            push_cmd,
    input  logic                     push_ready
);
    import hsi_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_SQX, F_SQY, F_ROOT, F_DIV, F_PUSH} fstate_t;

    localparam int D2_W = 34;
    localparam logic [D2_W-1:0] THRESH = D2_W'(1) << (2 * FRAC_BITS);
    localparam logic [VEL_W-1:0] STEP_LONG  = VEL_W'(STEP_LONG_PX << FRAC_BITS);
    localparam logic [VEL_W-1:0] STEP_SHORT = VEL_W'(STEP_SHORT_PX << FRAC_BITS);
    localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_STEPS);

    fstate_t                 state_reg;
    logic [1:0]              mode_reg;
    logic [POS_W-1:0]        prev_x_reg, prev_y_reg, nx_reg, ny_reg;
    logic signed [VEL_W-1:0] vel_x_reg, vel_y_reg, dx_reg, dy_reg;
    logic [D2_W-1:0]         v_reg, res_reg, bit_reg, sq_reg;
    logic [4:0]              iter_reg;
    logic [VEL_W-1:0]        rrem_reg;
    logic [CNT_W-1:0]        n_reg;

    logic signed [2*VEL_W-1:0] sq_prod;
    logic [D2_W-1:0]           trial;
    logic [VEL_W-1:0]          step;

    assign in_ready  = (state_reg == F_IDLE);
    assign cfg_ready = 1'b1;
    assign push      = (state_reg == F_PUSH);
    assign step      = (mode_reg == MODE_EXPLOSIVE) ? STEP_LONG : STEP_SHORT;
    assign trial     = res_reg + bit_reg;
    assign sq_prod   = (state_reg == F_SQX) ? dx_reg * dx_reg : dy_reg * dy_reg;

    always_comb
    begin
        push_cmd.p0x  = prev_x_reg;
        push_cmd.p0y  = prev_y_reg;
        push_cmd.p1x  = nx_reg;
        push_cmd.p1y  = ny_reg;
        push_cmd.vx   = vel_x_reg;
        push_cmd.vy   = vel_y_reg;
        push_cmd.dx   = dx_reg;
        push_cmd.dy   = dy_reg;
        push_cmd.n    = n_reg;
        unique case (mode_reg)
            MODE_RAINBOW:   push_cmd.kind = KIND_RAINBOW;
            MODE_EXPLOSIVE: push_cmd.kind = KIND_EXPLOSIVE;
            default:        push_cmd.kind = KIND_BLUE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            mode_reg   <= 2'd0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            vel_x_reg  <= '0;
            vel_y_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        nx_reg <= pos_x;
                        ny_reg <= pos_y;
                        dx_reg <= $signed({1'b0, pos_x}) - $signed({1'b0, prev_x_reg});
                        dy_reg <= $signed({1'b0, pos_y}) - $signed({1'b0, prev_y_reg});
                        if (!pen_down)
                        begin
                            prev_x_reg <= pos_x;
                            prev_y_reg <= pos_y;
                            vel_x_reg  <= '0;
                            vel_y_reg  <= '0;
                        end
                        else
                        begin
                            state_reg <= F_SQX;
                        end
                    end
                end
                F_SQX:
                begin
                    sq_reg    <= D2_W'(unsigned'(sq_prod));
                    state_reg <= F_SQY;
                end
                F_SQY:
                begin
                    v_reg    <= sq_reg + D2_W'(unsigned'(sq_prod));
                    res_reg  <= '0;
                    bit_reg  <= D2_W'(1) << 32;
                    iter_reg <= '0;
                    if ((sq_reg + D2_W'(unsigned'(sq_prod))) <= THRESH)
                    begin
                        state_reg <= F_IDLE;
                    end
                    else
                    begin
                        state_reg <= F_ROOT;
                    end
                end
                F_ROOT:
                begin
                    if (v_reg >= trial)
                    begin
                        v_reg   <= v_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    iter_reg <= iter_reg + 5'd1;
                    if (iter_reg == 5'd16)
                    begin
                        state_reg <= F_DIV;
                        n_reg     <= CNT_W'(1);
                    end
                end
                F_DIV:
                begin
                    // Floor division by the step through repeated subtraction.
                    if (iter_reg == 5'd17)
                    begin
                        rrem_reg <= res_reg[VEL_W-1:0];
                        iter_reg <= '0;
                    end
                    else if (rrem_reg >= step && n_reg < N_MAX)
                    begin
                        rrem_reg <= rrem_reg - step;
                        n_reg    <= n_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (push_ready)
                    begin
                        prev_x_reg <= nx_reg;
                        prev_y_reg <= ny_reg;
                        vel_x_reg  <= dx_reg;
                        vel_y_reg  <= dy_reg;
                        state_reg  <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/hsi_queue.sv =====
// Short segment queue between the front and back parts.
module hsi_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hsi_pkg::cmd_t push_cmd,
    output logic          push_ready,
    input  logic          pop,
    output hsi_pkg::cmd_t pop_cmd,
    output logic          pop_valid
);
    import hsi_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            end
            count_reg <= count_reg + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

// ===== rtl/hsi_back.sv =====
// Back part: evaluates the Hermite curve point by point and rounds each coordinate.
module hsi_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  hsi_pkg::cmd_t                   cmd,
    output logic                            cmd_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [hsi_pkg::OUT_W-1:0] point_x,
    output logic signed [hsi_pkg::OUT_W-1:0] point_y,
    output logic [1:0]                      particle_kind,
    output logic                            last_point
);
    import hsi_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_N2, B_N3, B_I2, B_I3, B_H, B_MAC, B_DIVSET, B_DIV, B_OUT
    } bstate_t;

    localparam int N2W   = 2 * CNT_W;
    localparam int N3W   = 3 * CNT_W;
    localparam int HW    = N3W + 3;
    localparam int ACC_W = N3W + 22;
    localparam int DCW   = $clog2(ACC_W);
    localparam int VW    = VEL_W + 1;
    localparam logic signed [ACC_W:0] OUT_HI = (ACC_W+1)'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W:0] OUT_LO = -(ACC_W+1)'(1 << (OUT_W - 1));

    bstate_t                  state_reg;
    cmd_t                     cmd_reg;
    logic [CNT_W-1:0]         i_reg;
    logic [N2W-1:0]           n2_reg, i2_reg;
    logic [N3W-1:0]           n3_reg, i3_reg, i2n_reg, in2_reg;
    logic signed [HW-1:0]     h_reg [4];
    logic [1:0]               term_reg;
    logic signed [ACC_W-1:0]  accx_reg, accy_reg;
    logic                     negx_reg, negy_reg;
    logic [ACC_W-1:0]         dvdx_reg, dvdy_reg;
    logic [N3W:0]             remx_reg, remy_reg, div_reg;
    logic [DCW-1:0]           dcnt_reg;

    logic signed [HW-1:0]     i3s, i2ns, in2s, n3s;
    logic signed [VW-1:0]     valx, valy;
    logic signed [ACC_W-1:0]  qx, qy;
    logic [N3W+1:0]           shx, shy;
    logic                     gex, gey;
    logic signed [ACC_W:0]    fx, fy;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W:0] v);
        if (v > OUT_HI)
        begin
            return OUT_HI[OUT_W-1:0];
        end
        else if (v < OUT_LO)
        begin
            return OUT_LO[OUT_W-1:0];
        end
        return v[OUT_W-1:0];
    endfunction

    // Floor of a signed quotient from the unsigned quotient and remainder.
    function automatic logic signed [ACC_W:0] fix_q(input logic neg,
                                                   input logic [ACC_W-1:0] q,
                                                   input logic [N3W:0] r);
        logic signed [ACC_W:0] qs;
        qs = $signed({1'b0, q});
        if (!neg)
        begin
            return qs;
        end
        return (r != '0) ? -(qs + (ACC_W+1)'(1)) : -qs;
    endfunction

    assign cmd_pop = (state_reg == B_IDLE) && cmd_valid;

    assign i3s  = $signed({3'b000, i3_reg});
    assign i2ns = $signed({3'b000, i2n_reg});
    assign in2s = $signed({3'b000, in2_reg});
    assign n3s  = $signed({3'b000, n3_reg});

    always_comb
    begin
        unique case (term_reg)
            2'd0:
            begin
                valx = $signed({2'b00, cmd_reg.p0x});
                valy = $signed({2'b00, cmd_reg.p0y});
            end
            2'd1:
            begin
                valx = $signed({2'b00, cmd_reg.p1x});
                valy = $signed({2'b00, cmd_reg.p1y});
            end
            2'd2:
            begin
                valx = VW'(cmd_reg.vx);
                valy = VW'(cmd_reg.vy);
            end
            default:
            begin
                valx = VW'(cmd_reg.dx);
                valy = VW'(cmd_reg.dy);
            end
        endcase
    end

    assign qx  = (accx_reg <<< 1) + ACC_W'(n3s);
    assign qy  = (accy_reg <<< 1) + ACC_W'(n3s);
    assign shx = {remx_reg, dvdx_reg[ACC_W-1]};
    assign shy = {remy_reg, dvdy_reg[ACC_W-1]};
    assign gex = (shx >= {1'b0, div_reg});
    assign gey = (shy >= {1'b0, div_reg});
    assign fx  = fix_q(negx_reg, dvdx_reg, remx_reg);
    assign fy  = fix_q(negy_reg, dvdy_reg, remy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            // A beat taken while the next point is ready is replaced in B_OUT instead.
            if (out_valid && out_ready && (state_reg != B_OUT))
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        i_reg     <= CNT_W'(1);
                        state_reg <= B_N2;
                    end
                end
                B_N2:
                begin
                    n2_reg    <= cmd_reg.n * cmd_reg.n;
                    state_reg <= B_N3;
                end
                B_N3:
                begin
                    n3_reg    <= n2_reg * cmd_reg.n;
                    state_reg <= B_I2;
                end
                B_I2:
                begin
                    i2_reg    <= i_reg * i_reg;
                    state_reg <= B_I3;
                end
                B_I3:
                begin
                    i3_reg    <= i2_reg * i_reg;
                    i2n_reg   <= i2_reg * cmd_reg.n;
                    in2_reg   <= n2_reg * i_reg;
                    state_reg <= B_H;
                end
                B_H:
                begin
                    h_reg[0]  <= (i3s <<< 1) - ((i2ns <<< 1) + i2ns) + n3s;
                    h_reg[1]  <= ((i2ns <<< 1) + i2ns) - (i3s <<< 1);
                    h_reg[2]  <= i3s - (i2ns <<< 1) + in2s;
                    h_reg[3]  <= i3s - i2ns;
                    accx_reg  <= '0;
                    accy_reg  <= '0;
                    term_reg  <= 2'd0;
                    state_reg <= B_MAC;
                end
                B_MAC:
                begin
                    accx_reg <= accx_reg + ACC_W'(h_reg[term_reg] * valx);
                    accy_reg <= accy_reg + ACC_W'(h_reg[term_reg] * valy);
                    term_reg <= term_reg + 2'd1;
                    if (term_reg == 2'd3)
                    begin
                        state_reg <= B_DIVSET;
                    end
                end
                B_DIVSET:
                begin
                    // Round to nearest with ties up: floor((2p + n^3) / 2n^3).
                    negx_reg  <= qx[ACC_W-1];
                    negy_reg  <= qy[ACC_W-1];
                    dvdx_reg  <= qx[ACC_W-1] ? ACC_W'(-qx) : ACC_W'(qx);
                    dvdy_reg  <= qy[ACC_W-1] ? ACC_W'(-qy) : ACC_W'(qy);
                    remx_reg  <= '0;
                    remy_reg  <= '0;
                    div_reg   <= {n3_reg, 1'b0};
                    dcnt_reg  <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    remx_reg <= gex ? (N3W+1)'(shx - {1'b0, div_reg}) : shx[N3W:0];
                    remy_reg <= gey ? (N3W+1)'(shy - {1'b0, div_reg}) : shy[N3W:0];
                    dvdx_reg <= {dvdx_reg[ACC_W-2:0], gex};
                    dvdy_reg <= {dvdy_reg[ACC_W-2:0], gey};
                    dcnt_reg <= dcnt_reg + DCW'(1);
                    if (dcnt_reg == DCW'(ACC_W - 1))
                    begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (!out_valid || out_ready)
                    begin
                        point_x       <= sat_out(fx);
                        point_y       <= sat_out(fy);
                        particle_kind <= cmd_reg.kind;
                        last_point    <= (i_reg == cmd_reg.n);
                        out_valid     <= 1'b1;
                        if (i_reg == cmd_reg.n)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + CNT_W'(1);
                            state_reg <= B_I2;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/hermite_stroke_interpolator_top.sv =====
// Top level of the Hermite stroke interpolator.
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_ready     pen_down, pos_x, pos_y
//   out       output     out_valid / out_ready   point_x, point_y, particle_kind, last_point
//   cfg       input      cfg_valid / cfg_ready   cfg_data (brush_mode)
//
// The front part takes no new sample until it has handled the last; a drawing sample goes
// through the bit-per-cycle square root and the step-count subtraction loop, while a
// pen-up sample or a move of at most one pixel skips both.
// The back part rounds each curve point in the bit-serial rounding divider, and finds n^2
// and n^3 once at the start of each segment.
// A two-entry segment queue lets the front part take new samples while points are out.
// Reset is asynchronous and clears the stroke state, mode and handshake state at once.
// A stalled out_ready holds the current point and stops the back part; the front part
// stalls only once the queue is full.
module hermite_stroke_interpolator_top #(
    parameter int MAX_STEPS = hsi_pkg::MAX_STEPS_DEF,
    parameter int FRAC_BITS = hsi_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             pen_down,
    input  logic [hsi_pkg::POS_W-1:0]         pos_x,
    input  logic [hsi_pkg::POS_W-1:0]         pos_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [hsi_pkg::OUT_W-1:0]  point_x,
    output logic signed [hsi_pkg::OUT_W-1:0]  point_y,
    output logic [1:0]                       particle_kind,
    output logic                             last_point,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_data
);
    import hsi_pkg::*;

    cmd_t push_cmd, pop_cmd;
    logic push, push_ready, pop, pop_valid;

    hsi_front #(
        .MAX_STEPS (MAX_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pen_down   (pen_down),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    hsi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid)
    );

    hsi_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (pop_valid),
        .cmd           (pop_cmd),
        .cmd_pop       (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .point_x       (point_x),
        .point_y       (point_y),
        .particle_kind (particle_kind),
        .last_point    (last_point)
    );

endmodule
